// ----- src/pfe_pkg.sv -----
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and character tables for the printf format engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // input command codes
  localparam logic [1:0] CMD_FMT     = 2'd0;
  localparam logic [1:0] CMD_STR     = 2'd1;
  localparam logic [1:0] CMD_STR_END = 2'd2;
  localparam logic [1:0] CMD_FMT_END = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_MINUS   = 8'h2d;

  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int ARG_W      = 32;
  localparam int CNT_W      = 31;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // output character sources
  localparam logic [2:0] SRC_BYTE  = 3'd0;
  localparam logic [2:0] SRC_DIGIT = 3'd1;
  localparam logic [2:0] SRC_MINUS = 3'd2;
  localparam logic [2:0] SRC_NULL  = 3'd3;
  localparam logic [2:0] SRC_COUNT = 3'd4;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [7:0]              byte_req;
    logic signed [ARG_W-1:0] arg_value;
    logic                    arg_null;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             is_count;
    logic [CNT_W-1:0] char_count;
    logic             last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load_dec;
    logic       load_hex;
    logic       dd_step;
    logic       push;
    logic [2:0] src;
    logic       last;
    logic       cnt_clr;
    logic [3:0] sel;
  } pfe_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic digit_zero;
  } pfe_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    c = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
    return c;
  endfunction

  function automatic logic [7:0] null_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = 8'h28; // (
      4'd1:    c = 8'h6e; // n
      4'd2:    c = 8'h75; // u
      4'd3:    c = 8'h6c; // l
      4'd4:    c = 8'h6c; // l
      default: c = 8'h29; // )
    endcase
    return c;
  endfunction

endpackage

// ----- src/printf_format_engine.sv -----
// ----------------------------------------------------------------------------
// printf_format_engine
// Small printf engine for %d, %x and %s over a format and argument stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data) carries format bytes, string
// argument bytes, end-of-string and end-of-format items. Output channel
// (out_valid/out_stall/out_data) carries one transaction per character, and
// one count transaction for each end-of-format item; last marks the final
// transaction caused by an input item.
// Plain bytes, string bytes and the count pass at one item per cycle while
// out_stall is low, through the output register. %d holds the input through
// the accept, a binary to BCD shift (S_CONV), a skip of leading zeros that
// keeps at least one digit (S_SKIP), then the digits (S_DIGITS). %x holds it
// the same way: accept, skip of leading zero nibbles, digits. "(null)" holds
// it for the accept and its six characters. Input stalls while a conversion
// runs and while the output register is held by out_stall. No transaction is
// lost or repeated under stall.
// Reset (rst, synchronous) clears the parser state, count and output valid.
// ----------------------------------------------------------------------------
module printf_format_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pfe_pkg::out_item_t out_data
);
  import pfe_pkg::*;

  pfe_cmd_t  cmd;
  pfe_stat_t stat;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfe_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- src/pfe_dpath.sv -----
// ----------------------------------------------------------------------------
// pfe_dpath
// Binary to BCD shifter, digit store, character count and output register.
// ----------------------------------------------------------------------------
module pfe_dpath (
  input  logic              clk,
  input  logic              rst,
  input  pfe_pkg::in_item_t in_data,
  input  pfe_pkg::pfe_cmd_t cmd,
  output pfe_pkg::pfe_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output pfe_pkg::out_item_t out_data
);
  import pfe_pkg::*;

  logic [DEC_DIGITS-1:0][3:0] dig;
  logic [DEC_DIGITS-1:0][3:0] dig_adj;
  logic [4*DEC_DIGITS-1:0]    adj_bits;
  logic [ARG_W-1:0]           bin;
  logic [ARG_W-1:0]           mag;
  logic [CNT_W-1:0]           emitted_count;
  logic [3:0]                 cur_digit;
  logic [7:0]                 ch;
  out_item_t                  item_next;

  assign cur_digit       = dig[cmd.sel];
  assign stat.digit_zero = (cur_digit == 4'd0);
  assign stat.out_free   = !out_valid || !out_stall;

  // 0x80000000 maps to itself, which is its correct magnitude
  assign mag = in_data.arg_value[ARG_W-1] ? (ARG_W'(0) - ARG_W'(in_data.arg_value))
                                          : ARG_W'(in_data.arg_value);

  // add-3 correction ahead of each shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      dig_adj[i] = (dig[i] >= 4'd5) ? (dig[i] + 4'd3) : dig[i];
    end
  end

  assign adj_bits = dig_adj;

  always_ff @(posedge clk) begin
    if (cmd.load_dec) begin
      dig <= '0;
      bin <= mag;
    end else if (cmd.load_hex) begin
      dig <= {8'd0, ARG_W'(in_data.arg_value)};
    end else if (cmd.dd_step) begin
      dig <= {adj_bits[4*DEC_DIGITS-2:0], bin[ARG_W-1]};
      bin <= {bin[ARG_W-2:0], 1'b0};
    end
  end

  always_comb begin
    unique case (cmd.src)
      SRC_BYTE:  ch = in_data.byte_req;
      SRC_DIGIT: ch = hex_char(cur_digit);
      SRC_MINUS: ch = CH_MINUS;
      SRC_NULL:  ch = null_char(cmd.sel);
      default:   ch = 8'd0;
    endcase
    item_next.out_char   = ch;
    item_next.is_count   = (cmd.src == SRC_COUNT);
    item_next.char_count = (cmd.src == SRC_COUNT) ? emitted_count : '0;
    item_next.last       = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
    end else if (cmd.cnt_clr) begin
      emitted_count <= '0;
    end else if (cmd.push && (cmd.src != SRC_COUNT) && (emitted_count != CNT_MAX)) begin
      emitted_count <= emitted_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= item_next;
    end
  end

endmodule

// ----- src/pfe_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfe_ctrl
// Format parser and conversion sequencer.
// ----------------------------------------------------------------------------
module pfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  input  pfe_pkg::pfe_stat_t stat,
  output pfe_pkg::pfe_cmd_t  cmd
);
  import pfe_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CONV   = 3'd1;
  localparam logic [2:0] S_SKIP   = 3'd2;
  localparam logic [2:0] S_DIGITS = 3'd3;
  localparam logic [2:0] S_NULL   = 3'd4;

  localparam logic [4:0] DD_LAST  = 5'(ARG_W - 1);
  localparam logic [4:0] DEC_TOP  = 5'(DEC_DIGITS - 1);
  localparam logic [4:0] HEX_TOP  = 5'(HEX_DIGITS - 1);
  localparam logic [4:0] NULL_END = 5'd5;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       pending, pending_next;
  logic       in_string, in_string_next;
  logic       acc;

  assign in_stall = !((state == S_IDLE) && stat.out_free);
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pending_next   = pending;
    in_string_next = in_string;
    cmd            = '0;
    cmd.sel        = cnt[3:0];
    cmd.src        = SRC_BYTE;

    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (in_data.cmd)
            CMD_FMT: begin
              in_string_next = 1'b0;
              if (pending) begin
                pending_next = 1'b0;
                if (in_data.byte_req == CH_D) begin
                  cmd.load_dec = 1'b1;
                  if (in_data.arg_value[ARG_W-1]) begin
                    cmd.push = 1'b1;
                    cmd.src  = SRC_MINUS;
                  end
                  cnt_next   = '0;
                  state_next = S_CONV;
                end else if (in_data.byte_req == CH_X) begin
                  cmd.load_hex = 1'b1;
                  cnt_next     = HEX_TOP;
                  state_next   = S_SKIP;
                end else if (in_data.byte_req == CH_S) begin
                  if (in_data.arg_null) begin
                    cnt_next   = '0;
                    state_next = S_NULL;
                  end else begin
                    in_string_next = 1'b1;
                  end
                end
              end else if (in_data.byte_req == CH_PERCENT) begin
                pending_next = 1'b1;
              end else begin
                cmd.push = 1'b1;
                cmd.last = 1'b1;
              end
            end
            CMD_STR: begin
              if (in_string) begin
                cmd.push = 1'b1;
                cmd.last = 1'b1;
              end
            end
            CMD_STR_END: begin
              in_string_next = 1'b0;
            end
            default: begin
              cmd.push       = 1'b1;
              cmd.src        = SRC_COUNT;
              cmd.last       = 1'b1;
              cmd.cnt_clr    = 1'b1;
              pending_next   = 1'b0;
              in_string_next = 1'b0;
            end
          endcase
        end
      end
      S_CONV: begin
        cmd.dd_step = 1'b1;
        if (cnt == DD_LAST) begin
          cnt_next   = DEC_TOP;
          state_next = S_SKIP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if ((cnt != '0) && stat.digit_zero) begin
          cnt_next = cnt - 1'b1;
        end else begin
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          cmd.src  = SRC_DIGIT;
          cmd.last = (cnt == '0);
          if (cnt == '0) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt - 1'b1;
          end
        end
      end
      S_NULL: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          cmd.src  = SRC_NULL;
          cmd.last = (cnt == NULL_END);
          if (cnt == NULL_END) begin
            state_next = S_IDLE;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pending   <= 1'b0;
      in_string <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pending   <= pending_next;
      in_string <= in_string_next;
    end
  end

endmodule

// ----- sim/pfe_stream_checker.sv -----
// ----------------------------------------------------------------------------
// pfe_stream_checker
// Watches both channels of the printf format engine and checks its output.
// Every accepted input transaction is expanded into the characters and count
// it should produce. Every accepted output transaction is compared field by
// field with the oldest of those, in order.
// ----------------------------------------------------------------------------
module pfe_stream_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  pfe_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  pfe_pkg::out_item_t out_data,
  output int                 errors,
  output int                 pending,
  output int                 items_taken,
  output int                 chars_seen,
  output int                 counts_seen
);
  import pfe_pkg::*;

  localparam logic [8*16-1:0] HEX_TABLE = "0123456789abcdef";
  localparam logic [8*6-1:0]  NULL_TEXT = "(null)";

  // predicted formatter state
  logic             percent_armed;
  logic             string_open;
  logic [CNT_W-1:0] char_total;

  out_item_t expected_chars[$];

  function automatic void emit_char(input logic [7:0] c);
    out_item_t r;
    r          = '0;
    r.out_char = c;
    expected_chars.push_back(r);
    if (char_total != CNT_MAX) char_total = char_total + 1'b1;
  endfunction

  function automatic void expand_item(input in_item_t it);
    int          before_n;
    logic [31:0] mag;
    logic [7:0]  digs [10];
    int          k;
    int          shift;
    int          d;
    out_item_t   tail;
    before_n = expected_chars.size();
    case (it.cmd)
      CMD_FMT: begin
        string_open = 1'b0;
        if (percent_armed) begin
          percent_armed = 1'b0;
          mag = it.arg_value;
          if (it.byte_req == CH_D) begin
            if (mag[31]) begin
              emit_char(CH_MINUS);
              mag = 32'd0 - mag; // most negative value keeps its pattern
            end
            k = 0;
            do begin
              digs[k] = 8'h30 + 8'(mag % 32'd10);
              mag     = mag / 32'd10;
              k++;
            end while (mag != 0 && k < 10);
            while (k > 0) begin
              k--;
              emit_char(digs[k]);
            end
          end else if (it.byte_req == CH_X) begin
            shift = 28;
            while (shift > 0 && mag[shift +: 4] == 4'd0) shift -= 4;
            for (; shift >= 0; shift -= 4) begin
              d = mag[shift +: 4];
              emit_char(HEX_TABLE[8*(15-d) +: 8]);
            end
          end else if (it.byte_req == CH_S) begin
            if (it.arg_null) begin
              for (k = 0; k < 6; k++) emit_char(NULL_TEXT[8*(5-k) +: 8]);
            end else begin
              string_open = 1'b1;
            end
          end
          // any other conversion byte just disarms
        end else if (it.byte_req == CH_PERCENT) begin
          percent_armed = 1'b1;
        end else begin
          emit_char(it.byte_req);
        end
      end
      CMD_STR: begin
        if (string_open) emit_char(it.byte_req);
      end
      CMD_STR_END: begin
        string_open = 1'b0;
      end
      default: begin
        tail            = '0;
        tail.is_count   = 1'b1;
        tail.char_count = char_total;
        expected_chars.push_back(tail);
        percent_armed = 1'b0;
        string_open   = 1'b0;
        char_total    = '0;
      end
    endcase
    if (expected_chars.size() > before_n) begin
      tail      = expected_chars.pop_back();
      tail.last = 1'b1;
      expected_chars.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      percent_armed = 1'b0;
      string_open   = 1'b0;
      char_total    = '0;
      expected_chars.delete();
      errors      = 0;
      items_taken = 0;
      chars_seen  = 0;
      counts_seen = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expand_item(in_data);
        items_taken++;
      end
      if (out_valid && !out_stall) begin
        if (out_data.is_count) counts_seen++;
        else chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected transaction: out_char %h is_count %b char_count %0d last %b",
                 out_data.out_char, out_data.is_count, out_data.char_count, out_data.last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.is_count !== want.is_count) begin
            $error("is_count: expected %b, got %b", want.is_count, out_data.is_count);
            errors++;
          end
          if (out_data.char_count !== want.char_count) begin
            $error("char_count: expected %0d, got %0d", want.char_count, out_data.char_count);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            errors++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ----- sim/printf_format_engine_test.sv -----
// ----------------------------------------------------------------------------
// printf_format_engine_test
// Stimulus and verdict for the printf format engine.
// A directed run covers field extremes and the odd corners of %d, %x and %s,
// then random format streams run under three stall mixes, including a long
// output hold-off that backs up the input. Checking lives in pfe_stream_checker.
// ----------------------------------------------------------------------------
module printf_format_engine_test;
  import pfe_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 150;
  localparam int PHASE_ITEMS  = 60;

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int errors;
  int pending;
  int items_taken;
  int chars_seen;
  int counts_seen;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int sent_items    = 0;
  int cycle_count   = 0;

  always #4 clk = ~clk;

  printf_format_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  pfe_stream_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .errors      (errors),
    .pending     (pending),
    .items_taken (items_taken),
    .chars_seen  (chars_seen),
    .counts_seen (counts_seen)
  );

  // receiver: random stalls, plus a long hold-off when the stimulus asks
  initial begin : rx_side
    int served;
    int hold_left;
    served    = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one input transaction; called and returns at a falling edge
  task automatic put(input logic [1:0] cmd, input logic [7:0] b,
                     input logic [31:0] val, input logic nul);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_data.cmd        <= cmd;
    in_data.byte_req   <= b;
    in_data.arg_value  <= val;
    in_data.arg_null   <= nul;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic put_simple(input logic [1:0] cmd, input logic [7:0] b);
    put(cmd, b, $urandom, 1'($urandom_range(1)));
  endtask

  task automatic conv(input logic [7:0] b, input logic [31:0] val, input logic nul);
    put_simple(CMD_FMT, CH_PERCENT);
    put(CMD_FMT, b, val, nul);
  endtask

  // sender pause until every expected transaction has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(6))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(15));
      3: return 32'd0 - 32'($urandom_range(999));
      4: return 32'($urandom_range(99999));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_format();
    int pieces;
    int n;
    int p;
    int j;
    pieces = $urandom_range(1, 6);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(9))
        0, 1, 2: put_simple(CMD_FMT, 8'($urandom_range(255)));
        3:       conv(CH_D, pick_arg(), 1'($urandom_range(1)));
        4:       conv(CH_X, pick_arg(), 1'($urandom_range(1)));
        5:       conv(CH_S, $urandom, 1'b1);
        6, 7: begin
          conv(CH_S, $urandom, 1'b0);
          n = $urandom_range(6);
          for (j = 0; j < n; j++) put_simple(CMD_STR, 8'($urandom_range(255)));
          // sometimes left open, closed by the next format byte or the end
          if ($urandom_range(3) != 0) put_simple(CMD_STR_END, 8'($urandom_range(255)));
        end
        8: begin
          case ($urandom_range(3))
            0: put_simple(CMD_STR, 8'($urandom_range(255)));
            1: put_simple(CMD_STR_END, 8'($urandom_range(255)));
            2: conv(8'($urandom_range(255)), $urandom, 1'($urandom_range(1)));
            default: put_simple(CMD_FMT, CH_PERCENT);
          endcase
        end
        default: put_simple(CMD_FMT, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
    end
    put_simple(CMD_FMT_END, 8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int phase;
    int target;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corners, no idling
    put_simple(CMD_FMT, 8'h41);
    put_simple(CMD_FMT, 8'h00);
    put_simple(CMD_FMT, 8'hff);
    conv(CH_D, 32'h8000_0000, 1'b0);
    conv(CH_D, 32'h7fff_ffff, 1'b1);
    conv(CH_X, 32'h0000_0000, 1'b0);
    conv(CH_X, 32'hffff_ffff, 1'b1);
    conv(CH_S, 32'hffff_ffff, 1'b1);
    conv(CH_S, 32'h0000_0000, 1'b0);
    put(CMD_STR, 8'h00, 32'hffff_ffff, 1'b1);
    put(CMD_STR, 8'hff, 32'h0000_0000, 1'b0);
    put_simple(CMD_FMT, 8'h5a);          // implicitly closes the string
    put_simple(CMD_STR, 8'h71);          // ignored outside string mode
    put_simple(CMD_STR_END, 8'h00);      // ignored outside string mode
    conv(CH_PERCENT, 32'd5, 1'b0);       // double percent prints nothing
    put(CMD_FMT_END, 8'hff, 32'hffff_ffff, 1'b1);
    conv(CH_S, 32'd0, 1'b0);
    put_simple(CMD_STR, 8'h61);
    put_simple(CMD_FMT_END, 8'h00);      // end while string still open
    put_simple(CMD_FMT, CH_PERCENT);
    put_simple(CMD_FMT_END, 8'h00);      // trailing percent
    drain();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 14; recv_idle_pct = 87; end
        1:       begin send_idle_pct = 87; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      // back up the engine: output held while input keeps coming
      if (phase == 2) hold_requests++;
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) send_random_format();
      drain();
    end

    $display("Sent %0d input transactions (directed corners, random formats, three stall mixes).",
             items_taken);
    $display("Checked %0d characters and %0d count transactions.", chars_seen, counts_seen);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
